FILE: rtl/core/heightmap_normal_stencil_macros.svh
// Assertion helpers; the using module must have clk and rst_n in scope.
`ifndef HEIGHTMAP_NORMAL_STENCIL_MACROS_SVH
`define HEIGHTMAP_NORMAL_STENCIL_MACROS_SVH

// same-cycle implication
`define HNS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HNS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/hns_pkg.sv
`timescale 1ns / 1ps
package hns_pkg;

  localparam int ROW_W      = 10;
  localparam int COL_W      = 10;
  localparam int HS_W       = 16;
  localparam int NX_W       = 16;
  localparam int NY_W       = 15;
  localparam int DIFF_W     = 17;
  localparam int MAG_W      = 16;
  localparam int SQ_W       = 32;
  localparam int YSQ_W      = 30;
  localparam int SUM_W      = 34;
  localparam int GRID_CFG_W = 11;
  localparam int UP_W       = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam int DIV_STEPS  = 31;
  localparam int SQRT_STEPS = 16;
  localparam int ROOT_W     = 16;
  localparam int SREM_W     = 18;
  localparam int SOP_W      = 32;
  localparam int SCALE_LAT  = 1 + DIV_STEPS + SQRT_STEPS;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam int GRID_MIN = 3;
  localparam int GRID_MAX = 1024;

  localparam logic [GRID_CFG_W-1:0] WIDTH_RST  = 11'd256;
  localparam logic [GRID_CFG_W-1:0] HEIGHT_RST = 11'd256;
  localparam logic [UP_W-1:0]       UP_RST     = 15'd2560;
  localparam logic [NY_W-1:0]       UNIT_Q14   = 15'd16384;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_COMPONENT = 2'd2;

  typedef struct packed {
    logic [GRID_CFG_W-1:0] width_u;
    logic [GRID_CFG_W-1:0] height_u;
    logic [UP_W-1:0]       up_u;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic                     border;
    logic signed [DIFF_W-1:0] x;
    logic signed [DIFF_W-1:0] z;
  } work_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             border;
    logic             neg_x;
    logic             neg_z;
  } tag_t;

endpackage

FILE: rtl/core/hns_if.sv
`timescale 1ns / 1ps
interface hns_in_if;
  import hns_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [HS_W-1:0] height_sample;
  logic                   frame_start;
  modport source (output valid, height_sample, frame_start, input ready);
  modport sink (input valid, height_sample, frame_start, output ready);
endinterface

interface hns_out_if;
  import hns_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [ROW_W-1:0]       vertex_row;
  logic [COL_W-1:0]       vertex_col;
  logic signed [NX_W-1:0] normal_x;
  logic [NY_W-1:0]        normal_y;
  logic signed [NX_W-1:0] normal_z;
  modport source (output valid, vertex_row, vertex_col, normal_x, normal_y, normal_z,
                  input ready);
  modport sink (input valid, vertex_row, vertex_col, normal_x, normal_y, normal_z,
                output ready);
endinterface

FILE: rtl/core/heightmap_normal_stencil.sv
`timescale 1ns / 1ps
// Channel  Dir  Carries
// in_ch    in   height_sample (s16 Q8.8), frame_start
// out_ch   out  vertex_row, vertex_col, normal_x/z (s16 Q1.14), normal_y (u15 Q1.14)
// cfg_*    in   grid_width (0), grid_height (1), up_component (2)
//
// One sample accepted per cycle; sample (r,c) yields the normal of (r-1,c).
// With an empty queue and no stalls a result passes, after its sample is accepted,
// through the line buffer read, queue, squares, 31-step divider and
// 16-step square root pipelines and output register.
// Synchronous active-low reset loads the register defaults and clears
// counters, queue and valid bits; line buffers are not cleared.
// An output stall freezes the back pipeline; input stalls once the queue fills.
module heightmap_normal_stencil #(
  parameter int MAX_WIDTH   = 1024,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  hns_in_if.sink                         in_ch,
  hns_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [hns_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hns_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hns_pkg::*;

  localparam int WCAP = (MAX_WIDTH < GRID_MAX) ? MAX_WIDTH : GRID_MAX;

  logic [GRID_CFG_W-1:0] width_r, height_r;
  logic [UP_W-1:0]       up_r;
  cfg_t                  cfg;

  logic              push, pop, q_nonempty;
  work_t             push_item, q_head;
  logic [QCNT_W-1:0] q_level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      up_r     <= UP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH:   width_r  <= cfg_data[GRID_CFG_W-1:0];
        CFG_GRID_HEIGHT:  height_r <= cfg_data[GRID_CFG_W-1:0];
        CFG_UP_COMPONENT: up_r     <= cfg_data[UP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r < GRID_CFG_W'(GRID_MIN)) begin
      cfg.width_u = GRID_CFG_W'(GRID_MIN);
    end else if (width_r > GRID_CFG_W'(WCAP)) begin
      cfg.width_u = GRID_CFG_W'(WCAP);
    end else begin
      cfg.width_u = width_r;
    end
    if (height_r < GRID_CFG_W'(GRID_MIN)) begin
      cfg.height_u = GRID_CFG_W'(GRID_MIN);
    end else if (height_r > GRID_CFG_W'(GRID_MAX)) begin
      cfg.height_u = GRID_CFG_W'(GRID_MAX);
    end else begin
      cfg.height_u = height_r;
    end
    cfg.up_u = (up_r == '0) ? UP_W'(1) : up_r;
  end

  hns_front #(.MAX_WIDTH(MAX_WIDTH), .HEIGHT_BITS(HEIGHT_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .q_level   (q_level),
    .push      (push),
    .push_item (push_item)
  );

  hns_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (q_head),
    .nonempty  (q_nonempty),
    .level     (q_level)
  );

  hns_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .pop        (pop),
    .out_ch     (out_ch)
  );
endmodule

FILE: rtl/core/hns_ram.sv
`timescale 1ns / 1ps
module hns_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: rtl/core/hns_scale.sv
`timescale 1ns / 1ps
// mag = floor(sqrt(a2) * 16384 / sqrt(s) + 1/2), via q = floor(a2 * 2^30 / s),
// then mag = (isqrt(q) + 1) / 2. Restoring divide then digit-by-digit root.
module hns_scale (
  input  logic                       clk,
  input  logic                       en,
  input  logic [hns_pkg::SQ_W-1:0]   a2,
  input  logic [hns_pkg::SUM_W-1:0]  s,
  output logic [hns_pkg::NY_W-1:0]   mag
);
  import hns_pkg::*;

  logic [SUM_W-1:0]     drem_r [DIV_STEPS];
  logic [SUM_W-1:0]     ds_r   [DIV_STEPS];
  logic [DIV_STEPS-1:0] dq_r   [1:DIV_STEPS];
  logic                 dlo_r;

  logic [ROOT_W-1:0] srt_r [1:SQRT_STEPS];
  logic [SREM_W-1:0] srm_r [1:SQRT_STEPS-1];
  logic [SOP_W-1:0]  sop_r [1:SQRT_STEPS-1];

  // a2 <= s, so the top quotient bits are zero: start from a2 >> 1
  always_ff @(posedge clk) begin
    if (en) begin
      drem_r[0] <= SUM_W'(a2 >> 1);
      ds_r[0]   <= s;
      dlo_r     <= a2[0];
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [SUM_W:0]       sh;
    logic [SUM_W:0]       df;
    logic [DIV_STEPS-1:0] q_in;
    logic                 nb;

    if (k == 0) begin : g_first
      assign sh   = {drem_r[k], dlo_r};
      assign q_in = '0;
    end else begin : g_rest
      assign sh   = {drem_r[k], 1'b0};
      assign q_in = dq_r[k];
    end

    assign df = sh - {1'b0, ds_r[k]};
    assign nb = ~df[SUM_W];

    always_ff @(posedge clk) begin
      if (en) begin
        dq_r[k+1] <= {q_in[DIV_STEPS-2:0], nb};
      end
    end

    if (k < DIV_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          drem_r[k+1] <= nb ? df[SUM_W-1:0] : sh[SUM_W-1:0];
          ds_r[k+1]   <= ds_r[k];
        end
      end
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    logic [ROOT_W-1:0] root_in;
    logic [SREM_W-1:0] rem_in;
    logic [SOP_W-1:0]  op_in;
    logic [SREM_W+1:0] sh;
    logic [SREM_W+1:0] trial;
    logic [SREM_W+1:0] df;
    logic              ok;

    if (j == 0) begin : g_first
      assign root_in = '0;
      assign rem_in  = '0;
      assign op_in   = {1'b0, dq_r[DIV_STEPS]};
    end else begin : g_rest
      assign root_in = srt_r[j];
      assign rem_in  = srm_r[j];
      assign op_in   = sop_r[j];
    end

    assign sh    = {rem_in, op_in[SOP_W-1:SOP_W-2]};
    assign trial = (SREM_W+2)'({root_in, 2'b01});
    assign df    = sh - trial;
    assign ok    = (sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        srt_r[j+1] <= {root_in[ROOT_W-2:0], ok};
      end
    end

    if (j < SQRT_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          srm_r[j+1] <= ok ? df[SREM_W-1:0] : sh[SREM_W-1:0];
          sop_r[j+1] <= op_in << 2;
        end
      end
    end
  end

  logic [ROOT_W:0] rnd;
  assign rnd = (ROOT_W+1)'(srt_r[SQRT_STEPS]) + 1'b1;
  assign mag = rnd[NY_W:1];
endmodule

FILE: rtl/core/hns_front.sv
`timescale 1ns / 1ps
// Raster counters, two line buffers and the stencil operands.
module hns_front #(
  parameter int MAX_WIDTH   = 1024,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  hns_in_if.sink                     in_ch,
  input  hns_pkg::cfg_t              cfg,
  input  logic [hns_pkg::QCNT_W-1:0] q_level,
  output logic                       push,
  output hns_pkg::work_t             push_item
);
  import hns_pkg::*;

  localparam int SB = (HEIGHT_BITS < HS_W) ? HEIGHT_BITS : HS_W;
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = 13;
  localparam int LW = QCNT_W + 1;

  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;

  logic                   s2_vld_r;
  logic                   s2_emit_r;
  logic                   s2_int_r;
  logic [ROW_W-1:0]       s2_row_r;
  logic [COL_W-1:0]       s2_col_r;
  logic [AW-1:0]          s2_addr_r;
  logic signed [HS_W-1:0] s2_smp_r;
  logic signed [HS_W-1:0] cen_r;
  logic signed [HS_W-1:0] lft_r;

  logic                   accept;
  logic [ROW_W-1:0]       r_in;
  logic [COL_W-1:0]       c_raw, c_use;
  logic [GRID_CFG_W-1:0]  c_inc, r_inc;
  logic                   wrap, emit, interior;
  logic [AW-1:0]          a_raddr;
  logic signed [HS_W-1:0] sample;
  logic [SB-1:0]          a_rd, b_rd;
  logic signed [HS_W-1:0] right, above;
  logic signed [DIFF_W-1:0] x, z;

  assign in_ch.ready = (LW'(q_level) + LW'(s2_vld_r)) < LW'(QUEUE_DEPTH);
  assign accept      = in_ch.valid && in_ch.ready;
  assign sample      = HS_W'(signed'(in_ch.height_sample[SB-1:0]));

  always_comb begin
    r_in  = in_ch.frame_start ? '0 : row_r;
    c_raw = in_ch.frame_start ? '0 : col_r;
    c_use = (CW'(c_raw) >= CW'(MAX_WIDTH)) ? '0 : c_raw;
    emit  = (r_in >= ROW_W'(1)) && (GRID_CFG_W'(r_in) <= cfg.height_u - 1'b1);
    interior = emit && (r_in >= ROW_W'(2)) && (c_use >= COL_W'(1))
               && (GRID_CFG_W'(c_use) <= cfg.width_u - 2'd2)
               && ((CW'(c_use) + 1'b1) < CW'(MAX_WIDTH));
    c_inc = GRID_CFG_W'(c_use) + 1'b1;
    r_inc = GRID_CFG_W'(r_in) + 1'b1;
    wrap  = (c_inc >= cfg.width_u);
    col_nxt = wrap ? '0 : c_inc[COL_W-1:0];
    if (!wrap) begin
      row_nxt = r_in;
    end else if (r_inc >= cfg.height_u) begin
      row_nxt = '0;
    end else begin
      row_nxt = r_inc[ROW_W-1:0];
    end
    // right neighbor of this item; at row end it is the next item's center
    a_raddr = wrap ? '0 : AW'(c_inc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      col_r    <= '0;
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= accept;
      if (accept) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_emit_r <= emit;
      s2_int_r  <= interior;
      s2_row_r  <= r_in - 1'b1;
      s2_col_r  <= c_use;
      s2_addr_r <= AW'(c_use);
      s2_smp_r  <= sample;
    end
    if (s2_vld_r) begin
      cen_r <= right;
      lft_r <= cen_r;
    end
  end

  hns_ram #(.WIDTH(SB), .DEPTH(MAX_WIDTH)) u_line_prev (
    .clk   (clk),
    .we    (s2_vld_r),
    .waddr (s2_addr_r),
    .wdata (s2_smp_r[SB-1:0]),
    .re    (accept),
    .raddr (a_raddr),
    .rdata (a_rd)
  );

  hns_ram #(.WIDTH(SB), .DEPTH(MAX_WIDTH)) u_line_two (
    .clk   (clk),
    .we    (s2_vld_r),
    .waddr (s2_addr_r),
    .wdata (cen_r[SB-1:0]),
    .re    (accept),
    .raddr (AW'(c_use)),
    .rdata (b_rd)
  );

  assign right = HS_W'(signed'(a_rd));
  assign above = HS_W'(signed'(b_rd));
  assign x     = DIFF_W'(above) - DIFF_W'(s2_smp_r);
  assign z     = DIFF_W'(lft_r) - DIFF_W'(right);

  assign push             = s2_vld_r && s2_emit_r;
  assign push_item.row    = s2_row_r;
  assign push_item.col    = s2_col_r;
  assign push_item.border = ~s2_int_r;
  assign push_item.x      = s2_int_r ? x : '0;
  assign push_item.z      = s2_int_r ? z : '0;
endmodule

FILE: rtl/core/hns_queue.sv
`timescale 1ns / 1ps
`include "heightmap_normal_stencil_macros.svh"
module hns_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  hns_pkg::work_t             push_item,
  input  logic                       pop,
  output hns_pkg::work_t             head,
  output logic                       nonempty,
  output logic [hns_pkg::QCNT_W-1:0] level
);
  import hns_pkg::*;

  work_t             ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_item;
    end
  end

  assign head     = ent_r[rd_r];
  assign nonempty = (count_r != '0);
  assign level    = count_r;

  `HNS_ASSERT_NOW(a_no_overflow, push, count_r < QCNT_W'(QUEUE_DEPTH), "queue overflow")
  `HNS_ASSERT_NOW(a_no_underflow, pop, count_r != '0, "queue underflow")
  `HNS_ASSERT_NEXT(a_level_hold, !push && !pop, $stable(count_r), "queue level moved idle")
endmodule

FILE: rtl/core/hns_back.sv
`timescale 1ns / 1ps
// Squares, three scale units, sign and border fix-up, output register.
module hns_back (
  input  logic           clk,
  input  logic           rst_n,
  input  hns_pkg::cfg_t  cfg,
  input  logic           q_nonempty,
  input  hns_pkg::work_t q_head,
  output logic           pop,
  hns_out_if.source      out_ch
);
  import hns_pkg::*;

  logic en;
  logic out_vld_r;

  logic              a_vld_r;
  tag_t              a_tag_r;
  logic [SQ_W-1:0]   a_x2_r, a_z2_r;
  logic [YSQ_W-1:0]  a_y2_r;

  logic                     tvld_r [SCALE_LAT];
  tag_t                     tag_r  [SCALE_LAT];
  logic signed [DIFF_W-1:0] nx, nz;
  logic [MAG_W-1:0]         ax, az;
  logic [SUM_W-1:0]         s_sum;
  logic [NY_W-1:0]          mx, my, mz;
  tag_t                     t_end;

  // whole pipeline moves when the output register can take a value
  assign en  = !out_vld_r || out_ch.ready;
  assign pop = en && q_nonempty;

  assign nx = -q_head.x;
  assign nz = -q_head.z;
  assign ax = q_head.x[DIFF_W-1] ? nx[MAG_W-1:0] : q_head.x[MAG_W-1:0];
  assign az = q_head.z[DIFF_W-1] ? nz[MAG_W-1:0] : q_head.z[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_tag_r.row    <= q_head.row;
      a_tag_r.col    <= q_head.col;
      a_tag_r.border <= q_head.border;
      a_tag_r.neg_x  <= q_head.x[DIFF_W-1];
      a_tag_r.neg_z  <= q_head.z[DIFF_W-1];
      a_x2_r         <= ax * ax;
      a_z2_r         <= az * az;
      a_y2_r         <= cfg.up_u * cfg.up_u;
    end
  end

  assign s_sum = SUM_W'(a_x2_r) + SUM_W'(a_z2_r) + SUM_W'(a_y2_r);

  hns_scale u_scale_x (.clk(clk), .en(en), .a2(a_x2_r), .s(s_sum), .mag(mx));
  hns_scale u_scale_y (.clk(clk), .en(en), .a2(SQ_W'(a_y2_r)), .s(s_sum), .mag(my));
  hns_scale u_scale_z (.clk(clk), .en(en), .a2(a_z2_r), .s(s_sum), .mag(mz));

  for (genvar i = 0; i < SCALE_LAT; i++) begin : g_tag
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          tvld_r[i] <= 1'b0;
        end else if (en) begin
          tvld_r[i] <= a_vld_r;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          tag_r[i] <= a_tag_r;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          tvld_r[i] <= 1'b0;
        end else if (en) begin
          tvld_r[i] <= tvld_r[i-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          tag_r[i] <= tag_r[i-1];
        end
      end
    end
  end

  assign t_end = tag_r[SCALE_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= tvld_r[SCALE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.vertex_row <= t_end.row;
      out_ch.vertex_col <= t_end.col;
      if (t_end.border) begin
        out_ch.normal_x <= '0;
        out_ch.normal_y <= UNIT_Q14;
        out_ch.normal_z <= '0;
      end else begin
        out_ch.normal_x <= t_end.neg_x ? -NX_W'(mx) : NX_W'(mx);
        out_ch.normal_y <= my;
        out_ch.normal_z <= t_end.neg_z ? -NX_W'(mz) : NX_W'(mz);
      end
    end
  end

  assign out_ch.valid = out_vld_r;
endmodule

FILE: tb/heightmap_normal_stencil_tb.sv
`timescale 1ns / 1ps
module heightmap_normal_stencil_tb;
  import hns_pkg::*;

  localparam int CLK_HALF  = 4;
  localparam int LINE_LEN  = 1024;
  localparam int MAX_CYC   = 1000000;
  localparam int SETTLE    = 100;
  localparam int RAND_GOAL = 250;

  typedef struct {
    logic [ROW_W-1:0]       row;
    logic [COL_W-1:0]       col;
    logic signed [NX_W-1:0] nx;
    logic [NY_W-1:0]        ny;
    logic signed [NX_W-1:0] nz;
  } normal_t;

  // Tracks grid position and line buffers, predicts the normal of each vertex.
  class normal_scoreboard;
    logic [GRID_CFG_W-1:0] width_reg = WIDTH_RST;
    logic [GRID_CFG_W-1:0] height_reg = HEIGHT_RST;
    logic [UP_W-1:0]       up_reg = UP_RST;
    longint                prev_line [LINE_LEN];
    longint                older_line [LINE_LEN];
    int unsigned           row_cnt = 0;
    int unsigned           col_cnt = 0;
    normal_t               expected_q[$];
    int                    errors = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GRID_WIDTH:   width_reg = data[GRID_CFG_W-1:0];
        CFG_GRID_HEIGHT:  height_reg = data[GRID_CFG_W-1:0];
        CFG_UP_COMPONENT: up_reg = data[UP_W-1:0];
        default: ;
      endcase
    endfunction

    // Largest m with (2m-1)^2 * s <= 4 * a^2 * 2^28, i.e. round(a * 2^14 / sqrt(s)).
    function longint unsigned unit_mag(longint unsigned a, longint unsigned s);
      longint unsigned lo, hi, mid, t, rhs;
      rhs = a * a * (64'd4 << 28);
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        t = 2 * mid - 1;
        if (t * t * s <= rhs) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    function logic signed [NX_W-1:0] signed_unit(longint v, longint unsigned s);
      longint unsigned m;
      m = unit_mag((v < 0) ? -v : v, s);
      return (v < 0) ? NX_W'(-m) : NX_W'(m);
    endfunction

    function void note_sample(logic signed [HS_W-1:0] hs, logic fs);
      int unsigned w, h, r, c;
      longint x, y, z;
      longint unsigned s;
      normal_t e;
      w = (width_reg < GRID_MIN) ? GRID_MIN : (width_reg > GRID_MAX) ? GRID_MAX : width_reg;
      h = (height_reg < GRID_MIN) ? GRID_MIN : (height_reg > GRID_MAX) ? GRID_MAX : height_reg;
      if (fs) begin
        row_cnt = 0;
        col_cnt = 0;
      end
      r = row_cnt;
      c = col_cnt;
      if (c >= LINE_LEN) c = 0;
      if (r >= 1 && r <= h - 1) begin
        e.row = ROW_W'(r - 1);
        e.col = COL_W'(c);
        e.nx = '0;
        e.ny = UNIT_Q14;
        e.nz = '0;
        if (r >= 2 && r - 1 <= h - 2 && c >= 1 && c <= w - 2 && c + 1 < LINE_LEN) begin
          x = older_line[c] - longint'(hs);
          z = older_line[c-1] - prev_line[c+1];
          y = (up_reg == 0) ? 1 : up_reg;
          s = x * x + y * y + z * z;
          e.nx = signed_unit(x, s);
          e.ny = NY_W'(unit_mag(y, s));
          e.nz = signed_unit(z, s);
        end
        expected_q.push_back(e);
      end
      older_line[c] = prev_line[c];
      prev_line[c] = hs;
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      col_cnt = c;
      row_cnt = r;
    endfunction

    function void check_normal(normal_t act);
      normal_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected normal row=%0d col=%0d", $time, act.row, act.col);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (act.row !== e.row) begin
        $display("%0t: vertex_row exp %0d got %0d", $time, e.row, act.row);
        errors++;
      end
      if (act.col !== e.col) begin
        $display("%0t: vertex_col exp %0d got %0d", $time, e.col, act.col);
        errors++;
      end
      if (act.nx !== e.nx) begin
        $display("%0t: normal_x (%0d,%0d) exp %0d got %0d", $time, e.row, e.col, e.nx, act.nx);
        errors++;
      end
      if (act.ny !== e.ny) begin
        $display("%0t: normal_y (%0d,%0d) exp %0d got %0d", $time, e.row, e.col, e.ny, act.ny);
        errors++;
      end
      if (act.nz !== e.nz) begin
        $display("%0t: normal_z (%0d,%0d) exp %0d got %0d", $time, e.row, e.col, e.nz, act.nz);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  hns_in_if in_ch ();
  hns_out_if out_ch ();

  heightmap_normal_stencil u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  normal_scoreboard sb = new();

  int unsigned cyc = 0;
  int          burst_left = 0;
  int          rand_items = 0;
  bit          hold_req = 0;
  bit          hold_done = 0;
  int          hold_cnt = 0;
  int          rx_mode = 0;

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > MAX_CYC) begin
      $display("[heightmap_normal_stencil] ERROR");
      $finish;
    end
  end

  // Receiver: switches stall pattern every so often, plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1;
      hold_cnt = 600;
      out_ch.ready <= 1'b0;
    end else begin
      if (cyc % 150 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 99) < 60);
        2: out_ch.ready <= (cyc % 4 != 0);
        default: out_ch.ready <= ($urandom_range(0, 99) < 20);
      endcase
    end
  end

  always @(posedge clk) begin
    normal_t act;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      act.row = out_ch.vertex_row;
      act.col = out_ch.vertex_col;
      act.nx = out_ch.normal_x;
      act.ny = out_ch.normal_y;
      act.nz = out_ch.normal_z;
      sb.check_normal(act);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic set_grid(int w, int h, int up);
    write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_UP_COMPONENT, CFG_DATA_W'(up));
  endtask

  task automatic send_sample(logic signed [HS_W-1:0] hs, logic fs);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.height_sample <= hs;
    in_ch.frame_start <= fs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_sample(hs, fs);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [HS_W-1:0] pick_height(int mode);
    case (mode)
      0: return HS_W'($urandom());
      1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return $signed(16'($urandom_range(0, 511))) - 16'sd256;
    endcase
  endfunction

  // Frame start on the first item when mark_first is set; noise adds stray frame starts.
  task automatic run_frames(int n, int mode, bit mark_first, bit noise);
    logic fs;
    for (int i = 0; i < n; i++) begin
      fs = (i == 0 && mark_first) || (noise && $urandom_range(0, 99) < 2);
      send_sample(pick_height(mode == 3 ? $urandom_range(0, 2) : mode), fs);
    end
  endtask

  initial begin
    int w, h, up, n;
    in_ch.valid = 1'b0;
    in_ch.height_sample = '0;
    in_ch.frame_start = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 4x4 grid with full-scale height steps and the smallest up component.
    set_grid(4, 4, 1);
    for (int i = 0; i < 20; i++)
      send_sample((i % 3 == 0) ? 16'sh7FFF : (i % 3 == 1) ? 16'sh8000 : 16'sh0000, i == 0);
    drain();

    // Out-of-range sizes saturate; up of zero acts as one.
    set_grid(0, 0, 0);
    run_frames(3 * 3 * 2 + 1, 3, 1, 0);
    drain();
    set_grid(2047, 2047, 32767);
    run_frames(40, 3, 1, 0);
    drain();

    // Height shrunk mid frame: rows past the new height give no normal.
    set_grid(6, 8, 2560);
    run_frames(6 * 5 + 2, 0, 1, 0);
    drain();
    write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(3));
    run_frames(6 * 6, 0, 0, 0);
    drain();

    // Wide grid with the long receiver hold-off so the block backs up.
    set_grid(40, 4, $urandom_range(1, 32767));
    hold_req = 1;
    run_frames(200, 3, 1, 1);
    drain();

    while (rand_items < RAND_GOAL) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 64) : $urandom_range(3, 10);
      h = (w > 10) ? 3 : $urandom_range(3, 8);
      case ($urandom_range(0, 3))
        0: up = 1;
        1: up = 32767;
        default: up = $urandom_range(1, 32767);
      endcase
      set_grid(w, h, up);
      n = w * h * ((w > 10) ? 1 : $urandom_range(1, 2)) + $urandom_range(0, w);
      run_frames(n, $urandom_range(0, 3), 1, $urandom_range(0, 2) == 0);
      rand_items += n;
      drain();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[heightmap_normal_stencil] OK");
    end else begin
      $display("[heightmap_normal_stencil] ERROR");
    end
    $finish;
  end

endmodule
